// ----- src/lpht_pkg.sv -----
`default_nettype none

package lpht_pkg;

  // Default sizes
  localparam int unsigned TABLE_SIZE_DEF = 16;
  localparam int unsigned KEY_BITS_DEF   = 16;

  // Fixed field widths on the ports
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned KEY_PORT_W = 16;
  localparam int unsigned NAME_W     = 64;
  localparam int unsigned MARKS_W    = 10;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_W     = 4;

  // Request opcodes
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_MODIFY = 2'd2
  } action_e;

  // Response codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FOUND   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ----- src/lpht_in_if.sv -----
`default_nettype none

interface lpht_in_if;
  import lpht_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [KEY_PORT_W-1:0] key;
  logic [NAME_W-1:0]     name_tag;
  logic [MARKS_W-1:0]    marks;

  modport source (output valid, output action, output key, output name_tag,
                  output marks, input ready);
  modport sink   (input valid, input action, input key, input name_tag,
                  input marks, output ready);
endinterface

`default_nettype wire

// ----- src/lpht_out_if.sv -----
`default_nettype none

interface lpht_out_if;
  import lpht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

// ----- src/lpht_mod.sv -----
`default_nettype none

// Remainder of a key by TABLE_SIZE through a reciprocal multiply and one corrective subtract.
// Pipelined through the stage valids s1_q, s2_q and done_q: done_o goes high with rem_o valid.
module lpht_mod #(
  parameter int unsigned TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
  parameter int unsigned KEY_W      = lpht_pkg::KEY_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [KEY_W-1:0]              val_i,
  output logic                          done_o,
  output logic [$clog2(TABLE_SIZE)-1:0] rem_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
  localparam int unsigned RW    = KEY_W + IDX_W + 1;
  // floor(2^KEY_W / TABLE_SIZE): the quotient estimate is exact or one low
  localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / 64'(TABLE_SIZE));
  localparam logic [RW-1:0]    TS    = RW'(TABLE_SIZE);

  logic               s1_q;
  logic               s2_q;
  logic               done_q;
  logic [KEY_W-1:0]   val_q;
  logic [KEY_W-1:0]   key2_q;
  logic [KEY_W-1:0]   quo_q;
  logic [IDX_W-1:0]   rem_q;
  logic [2*KEY_W-1:0] prod;
  logic [RW-1:0]      part_rem;
  logic [RW-1:0]      rem_fix;

  // Quotient estimate, then key minus quotient times size, then one correction
  assign prod     = (2*KEY_W)'(val_q) * (2*KEY_W)'(RECIP);
  assign part_rem = RW'(key2_q) - RW'(quo_q) * TS;
  assign rem_fix  = (part_rem >= TS) ? part_rem - TS : part_rem;

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= val_i;
    end
    if (s1_q) begin
      quo_q  <= prod[2*KEY_W-1:KEY_W];
      key2_q <= val_q;
    end
    if (s2_q) begin
      rem_q <= rem_fix[IDX_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- src/linear_probe_hash_table.sv -----
// Flow: the home slot comes from the reciprocal-multiply remainder, then the probe streams one
//   slot read per cycle over up to TABLE_SIZE slots, and the output register takes the result.
//   A replace-mode takeover adds a home read and an occupant hash; one slot fewer is probed.
// Throughput: one transaction at a time; the next is accepted as the result goes valid.
// Reset: slot memory swept empty with ready low; replace_mode resets to 0.
`default_nettype none

module linear_probe_hash_table #(
  parameter int unsigned TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
  parameter int unsigned KEY_BITS   = lpht_pkg::KEY_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpht_in_if.sink     in_i,
  lpht_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i
);
  import lpht_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
  localparam int unsigned KW    = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int unsigned CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int unsigned EXT_W = IDX_W + SLOT_W;
  localparam int unsigned REC_W = 1 + KW + NAME_W + MARKS_W;
  // Record layout: {valid, key, name, marks}
  localparam int unsigned VLD_B = REC_W - 1;
  localparam int unsigned KEY_L = NAME_W + MARKS_W;
  localparam int unsigned NAM_L = MARKS_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0] CNT_ALL  = CNT_W'(TABLE_SIZE);
  localparam logic [CNT_W-1:0] CNT_REST = CNT_W'(TABLE_SIZE - 1);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_HASH   = 8'b00000100,
    S_HCHECK = 8'b00001000,
    S_OHASH  = 8'b00010000,
    S_SCAN   = 8'b00100000,
    S_DONE   = 8'b01000000
  } state_e;

  // What a probe hit does
  typedef enum logic [1:0] {
    P_SEARCH  = 2'd0,
    P_MODIFY  = 2'd1,
    P_PUT_NEW = 2'd2,
    P_PUT_OLD = 2'd3
  } purpose_e;

  function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  state_e   state_q, state_d;
  purpose_e purpose_q, purpose_d;

  logic                 mode_q;
  logic [IDX_W-1:0]     clr_q, clr_d;
  logic [ACTION_W-1:0]  act_q, act_d;
  logic [KW-1:0]        key_q, key_d;
  logic [NAME_W-1:0]    name_q, name_d;
  logic [MARKS_W-1:0]   marks_q, marks_d;
  logic [REC_W-1:0]     occ_q, occ_d;
  logic [IDX_W-1:0]     h_q, h_d;
  logic [IDX_W-1:0]     iss_ptr_q, iss_ptr_d;
  logic [CNT_W-1:0]     iss_left_q, iss_left_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]     chk_ptr_q, chk_ptr_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic [SLOT_W-1:0]    res_slot_q, res_slot_d;
  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic [SLOT_W-1:0]    out_slot_q, out_slot_d;

  // Slot memory
  logic [REC_W-1:0]     mem_q [TABLE_SIZE];
  logic [REC_W-1:0]     rd_q;
  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  logic [REC_W-1:0]     mem_wdata;

  logic                 mod_start;
  logic [KW-1:0]        mod_val;
  logic                 mod_done;
  logic [IDX_W-1:0]     mod_rem;

  logic [REC_W-1:0]     new_rec;
  logic                 rd_vld;
  logic                 hit;
  logic [EXT_W-1:0]     chk_ext, h_ext;

  lpht_mod #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_W      (KW)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .val_i   (mod_val),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign new_rec = {1'b1, key_q, name_q, marks_q};
  assign rd_vld  = rd_q[VLD_B];
  assign hit     = chk_vld_q &&
                   ((purpose_q == P_PUT_NEW || purpose_q == P_PUT_OLD) ? !rd_vld :
                    (rd_vld && (rd_q[KEY_L +: KW] == key_q)));
  assign chk_ext = EXT_W'(chk_ptr_q);
  assign h_ext   = EXT_W'(h_q);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    purpose_d    = purpose_q;
    clr_d        = clr_q;
    act_d        = act_q;
    key_d        = key_q;
    name_d       = name_q;
    marks_d      = marks_q;
    occ_d        = occ_q;
    h_d          = h_q;
    iss_ptr_d    = iss_ptr_q;
    iss_left_d   = iss_left_q;
    chk_vld_d    = 1'b0;
    chk_ptr_d    = chk_ptr_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    mod_start    = 1'b0;
    mod_val      = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_i.valid) begin
          act_d   = in_i.action;
          key_d   = in_i.key[KW-1:0];
          name_d  = in_i.name_tag;
          marks_d = in_i.marks;
          case (in_i.action)
            ACT_INSERT, ACT_SEARCH, ACT_MODIFY: begin
              mod_start = 1'b1;
              mod_val   = in_i.key[KW-1:0];
              state_d   = S_HASH;
            end
            default: begin
              res_status_d = ST_MISSING;
              res_slot_d   = '0;
              state_d      = S_DONE;
            end
          endcase
        end
      end

      // Home slot known: pick the probe
      S_HASH: begin
        if (mod_done) begin
          h_d        = mod_rem;
          iss_ptr_d  = mod_rem;
          iss_left_d = CNT_ALL;
          state_d    = S_SCAN;
          case (act_q)
            ACT_INSERT: begin
              if (mode_q) begin
                mem_re    = 1'b1;
                mem_raddr = mod_rem;
                state_d   = S_HCHECK;
              end else begin
                purpose_d = P_PUT_NEW;
              end
            end
            ACT_SEARCH: purpose_d = P_SEARCH;
            default:    purpose_d = P_MODIFY;
          endcase
        end
      end

      // Replace mode: look at the home occupant
      S_HCHECK: begin
        if (!rd_vld) begin
          mem_we       = 1'b1;
          mem_waddr    = h_q;
          mem_wdata    = new_rec;
          res_status_d = ST_OK;
          res_slot_d   = h_ext[SLOT_W-1:0];
          state_d      = S_DONE;
        end else begin
          occ_d     = rd_q;
          mod_start = 1'b1;
          mod_val   = rd_q[KEY_L +: KW];
          state_d   = S_OHASH;
        end
      end

      // Occupant's own home decides takeover
      S_OHASH: begin
        if (mod_done) begin
          iss_ptr_d  = nxt(h_q);
          iss_left_d = CNT_REST;
          state_d    = S_SCAN;
          if (mod_rem != h_q) begin
            mem_we    = 1'b1;
            mem_waddr = h_q;
            mem_wdata = new_rec;
            purpose_d = P_PUT_OLD;
          end else begin
            purpose_d = P_PUT_NEW;
          end
        end
      end

      // Streamed probe: issue one read per cycle, check the previous one
      S_SCAN: begin
        if (hit) begin
          res_status_d = ST_OK;
          res_slot_d   = chk_ext[SLOT_W-1:0];
          state_d      = S_DONE;
          case (purpose_q)
            P_SEARCH: res_status_d = ST_FOUND;
            P_PUT_OLD: begin
              mem_we     = 1'b1;
              mem_waddr  = chk_ptr_q;
              mem_wdata  = occ_q;
              res_slot_d = h_ext[SLOT_W-1:0];
            end
            default: begin
              mem_we    = 1'b1;
              mem_waddr = chk_ptr_q;
              mem_wdata = new_rec;
            end
          endcase
        end else if (iss_left_q == '0 && !chk_vld_q) begin
          res_slot_d   = '0;
          res_status_d = (purpose_q == P_SEARCH || purpose_q == P_MODIFY) ?
                         ST_MISSING : ST_FULL;
          state_d      = S_DONE;
        end else if (iss_left_q != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = iss_ptr_q;
          chk_vld_d  = 1'b1;
          chk_ptr_d  = iss_ptr_q;
          iss_ptr_d  = nxt(iss_ptr_q);
          iss_left_d = iss_left_q - 1'b1;
        end
      end

      // Hand the result to the output register
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      iss_left_q  <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      iss_left_q  <= iss_left_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    purpose_q    <= purpose_d;
    act_q        <= act_d;
    key_q        <= key_d;
    name_q       <= name_d;
    marks_q      <= marks_d;
    occ_q        <= occ_d;
    h_q          <= h_d;
    iss_ptr_q    <= iss_ptr_d;
    chk_ptr_q    <= chk_ptr_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

  // Slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.slot_index = out_slot_q;

`ifndef NO_ASSERTIONS
  // The hash unit only finishes while the sequencer waits for it
  a_mod_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_HASH || state_q == S_OHASH))
    else $error("hash remainder arrived outside a wait state");

  // A held result blocks the next one from leaving DONE
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_o.ready) |=> (state_q == S_DONE))
    else $error("result overwrote a pending transaction");

  // No probe read is outstanding when a new probe begins
  a_scan_clean_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && $past(state_q) != S_SCAN) |-> !chk_vld_q)
    else $error("stale probe data at start of scan");
`endif

endmodule

`default_nettype wire
